FILE: rtl/dpa_pkg.sv
package dpa_pkg;

   // field components per frequency: Ex Ey Ez Hx Hy Hz
   localparam int NCOMP       = 6;
   localparam int COMP_H_BASE = 3;

   localparam int ACC_W   = 48;
   localparam int SPLIT_W = 32;
   localparam int CFG_W   = 32;
   localparam int NCFG    = 8;

   // Q4.28 value 1.0, reset value of the real norm registers
   localparam logic signed [CFG_W-1:0] NORM_ONE = 32'sh1000_0000;

   // output queue
   localparam int OUTQ_DEPTH = 8;
   localparam int OUTQ_AW    = 3;
   localparam int OUTQ_CW    = 4;

   // request modes; the spare code behaves as a read
   localparam logic [1:0] MODE_ACC  = 2'd0;
   localparam logic [1:0] MODE_NORM = 2'd1;

   typedef enum logic [2:0] {
      CSR_PHASE_E_RE,
      CSR_PHASE_E_IM,
      CSR_PHASE_H_RE,
      CSR_PHASE_H_IM,
      CSR_NORM_E_RE,
      CSR_NORM_E_IM,
      CSR_NORM_H_RE,
      CSR_NORM_H_IM
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_OK,
      ST_SAT,
      ST_DIV_ZERO
   } status_type;

   typedef enum logic [2:0] {
      NRM_IDLE,
      NRM_MUL,
      NRM_SUM,
      NRM_DOT,
      NRM_PREP,
      NRM_DIV,
      NRM_ROUND,
      NRM_DONE
   } nrm_state_type;

   typedef struct packed {
      logic [ACC_W-1:0] acc_re;
      logic [ACC_W-1:0] acc_im;
      status_type       status;
   } rsp_type;

   typedef struct packed {
      logic [ACC_W-1:0] x;
      logic [ACC_W-1:0] y;
      logic [CFG_W-1:0] c;
      logic [CFG_W-1:0] d;
   } norm_req_type;

   // Q.58 product rounded to Q.40, magnitude rounded half away from zero
   function automatic logic signed [ACC_W-1:0] round_phase(input logic signed [64:0] p);
      logic [63:0] mag;
      logic [64:0] rnd;
      logic [ACC_W-1:0] r;
      mag = p[64] ? 64'(-p) : p[63:0];
      rnd = {1'b0, mag} + 65'(1 << 17);
      r   = {1'b0, rnd[64:18]};
      return p[64] ? $signed(-r) : $signed(r);
   endfunction

   // clamp a 49-bit sum to 48 bits, flag in the top bit of the result
   function automatic logic [ACC_W:0] sat49(input logic signed [ACC_W:0] v);
      logic [ACC_W:0] r;
      if (v[ACC_W] != v[ACC_W-1]) begin
         r = {1'b1, v[ACC_W], {(ACC_W-1){~v[ACC_W]}}};
      end else begin
         r = {1'b0, v[ACC_W-1:0]};
      end
      return r;
   endfunction

endpackage

FILE: rtl/dpa_store.sv
module dpa_store #(
   parameter int DEPTH  = 49152,
   parameter int ADDR_W = 16,
   parameter int DATA_W = 96
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [DATA_W-1:0] wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [DATA_W-1:0] rdata
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // registered read port, old data on a same-address write
   always_ff @(posedge clock) begin
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/dpa_norm.sv
module dpa_norm import dpa_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  norm_req_type req,
   output logic         done,
   output rsp_type      rsp
);

   nrm_state_type state_ff, state_in;

   logic signed [ACC_W-1:0] x_ff, y_ff;
   logic signed [CFG_W-1:0] c_ff, d_ff;
   // partial products, high and low halves of x and y
   logic signed [56:0] xh_c_ff, xl_c_ff, yh_d_ff, yl_d_ff;
   logic signed [56:0] yh_c_ff, yl_c_ff, xh_d_ff, xl_d_ff;
   logic [63:0] cc_ff, dd_ff, den_ff;
   logic signed [79:0] xc_ff, yd_ff, yc_ff, xd_ff;
   logic signed [80:0] dot_re_ff, dot_im_ff;
   logic den_zero_ff;
   logic neg_re_ff, neg_im_ff, ovf_re_ff, ovf_im_ff;
   logic [63:0] rem_re_ff, rem_im_ff;
   logic [48:0] sh_re_ff, sh_im_ff, q_re_ff, q_im_ff;
   logic [5:0] cnt_ff;
   rsp_type rsp_ff;

   logic [79:0] mag_re, mag_im;
   logic ovf_re, ovf_im;
   logic [63:0] rem_re_in, rem_im_in;
   logic qb_re, qb_im;
   logic [ACC_W:0] fin_re, fin_im;

   function automatic logic signed [56:0] pmul(input logic signed [24:0] a,
                                               input logic signed [31:0] b);
      logic signed [56:0] r;
      r = a * b;
      return r;
   endfunction

   function automatic logic signed [79:0] pjoin(input logic signed [56:0] hi,
                                                input logic signed [56:0] lo);
      logic signed [79:0] r;
      r = (80'(hi) <<< 24) + 80'(lo);
      return r;
   endfunction

   // one restoring step: {quotient bit, new remainder}
   function automatic logic [64:0] div_step(input logic [63:0] rem, input logic b,
                                            input logic [63:0] den);
      logic [64:0] r2;
      logic [64:0] r;
      r2 = {rem, b};
      if (r2 >= {1'b0, den}) begin
         r = {1'b1, 64'(r2 - {1'b0, den})};
      end else begin
         r = {1'b0, r2[63:0]};
      end
      return r;
   endfunction

   // round half away, apply sign and clamp: {saturated, value}
   function automatic logic [ACC_W:0] finish(input logic neg, input logic ovf,
                                            input logic [48:0] q, input logic [63:0] rem,
                                            input logic [63:0] den);
      logic [49:0] qr;
      logic [49:0] lim;
      logic [ACC_W-1:0] v;
      logic [ACC_W:0] r;
      qr  = {1'b0, q} + 50'(rem >= (den - rem));
      lim = neg ? 50'(1) << 47 : (50'(1) << 47) - 50'(1);
      if (ovf || (qr > lim)) begin
         r = {1'b1, neg, {(ACC_W-1){~neg}}};
      end else begin
         v = qr[ACC_W-1:0];
         r = {1'b0, neg ? -v : v};
      end
      return r;
   endfunction

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= NRM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      unique case (state_ff)
         NRM_IDLE:  state_in = start ? NRM_MUL : NRM_IDLE;
         NRM_MUL:   state_in = NRM_SUM;
         NRM_SUM:   state_in = NRM_DOT;
         NRM_DOT:   state_in = NRM_PREP;
         NRM_PREP:  state_in = den_zero_ff ? NRM_ROUND : NRM_DIV;
         NRM_DIV:   state_in = (cnt_ff == 6'd0) ? NRM_ROUND : NRM_DIV;
         NRM_ROUND: state_in = NRM_DONE;
         NRM_DONE:  state_in = NRM_IDLE;
         default:   state_in = NRM_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      done = (state_ff == NRM_DONE);
      rsp  = rsp_ff;
   end

   // magnitudes and overflow test: mag*2^28 >= den*2^49
   always_comb begin
      mag_re = dot_re_ff[80] ? 80'(-dot_re_ff) : dot_re_ff[79:0];
      mag_im = dot_im_ff[80] ? 80'(-dot_im_ff) : dot_im_ff[79:0];
      ovf_re = {5'd0, mag_re} >= {den_ff, 21'd0};
      ovf_im = {5'd0, mag_im} >= {den_ff, 21'd0};
      {qb_re, rem_re_in} = div_step(rem_re_ff, sh_re_ff[48], den_ff);
      {qb_im, rem_im_in} = div_step(rem_im_ff, sh_im_ff[48], den_ff);
      fin_re = finish(neg_re_ff, ovf_re_ff, q_re_ff, rem_re_ff, den_ff);
      fin_im = finish(neg_im_ff, ovf_im_ff, q_im_ff, rem_im_ff, den_ff);
   end

   // datapath
   always_ff @(posedge clock) begin
      unique case (state_ff)
         NRM_IDLE: begin
            if (start) begin
               x_ff <= $signed(req.x);
               y_ff <= $signed(req.y);
               c_ff <= $signed(req.c);
               d_ff <= $signed(req.d);
            end
         end
         NRM_MUL: begin
            xh_c_ff <= pmul({x_ff[47], x_ff[47:24]}, c_ff);
            xl_c_ff <= pmul({1'b0, x_ff[23:0]}, c_ff);
            yh_d_ff <= pmul({y_ff[47], y_ff[47:24]}, d_ff);
            yl_d_ff <= pmul({1'b0, y_ff[23:0]}, d_ff);
            yh_c_ff <= pmul({y_ff[47], y_ff[47:24]}, c_ff);
            yl_c_ff <= pmul({1'b0, y_ff[23:0]}, c_ff);
            xh_d_ff <= pmul({x_ff[47], x_ff[47:24]}, d_ff);
            xl_d_ff <= pmul({1'b0, x_ff[23:0]}, d_ff);
            cc_ff   <= 64'(c_ff * c_ff);
            dd_ff   <= 64'(d_ff * d_ff);
         end
         NRM_SUM: begin
            xc_ff  <= pjoin(xh_c_ff, xl_c_ff);
            yd_ff  <= pjoin(yh_d_ff, yl_d_ff);
            yc_ff  <= pjoin(yh_c_ff, yl_c_ff);
            xd_ff  <= pjoin(xh_d_ff, xl_d_ff);
            den_ff <= cc_ff + dd_ff;
         end
         NRM_DOT: begin
            dot_re_ff   <= 81'(xc_ff) + 81'(yd_ff);
            dot_im_ff   <= 81'(yc_ff) - 81'(xd_ff);
            den_zero_ff <= (den_ff == 64'd0);
         end
         NRM_PREP: begin
            neg_re_ff <= dot_re_ff[80];
            neg_im_ff <= dot_im_ff[80];
            ovf_re_ff <= ovf_re;
            ovf_im_ff <= ovf_im;
            rem_re_ff <= 64'(mag_re[79:21]);
            rem_im_ff <= 64'(mag_im[79:21]);
            sh_re_ff  <= {mag_re[20:0], 28'd0};
            sh_im_ff  <= {mag_im[20:0], 28'd0};
            q_re_ff   <= '0;
            q_im_ff   <= '0;
            cnt_ff    <= 6'd48;
         end
         NRM_DIV: begin
            rem_re_ff <= rem_re_in;
            rem_im_ff <= rem_im_in;
            q_re_ff   <= {q_re_ff[47:0], qb_re};
            q_im_ff   <= {q_im_ff[47:0], qb_im};
            sh_re_ff  <= {sh_re_ff[47:0], 1'b0};
            sh_im_ff  <= {sh_im_ff[47:0], 1'b0};
            cnt_ff    <= cnt_ff - 6'd1;
         end
         NRM_ROUND: begin
            if (den_zero_ff) begin
               rsp_ff.acc_re <= x_ff;
               rsp_ff.acc_im <= y_ff;
               rsp_ff.status <= ST_DIV_ZERO;
            end else begin
               rsp_ff.acc_re <= fin_re[ACC_W-1:0];
               rsp_ff.acc_im <= fin_im[ACC_W-1:0];
               rsp_ff.status <= (fin_re[ACC_W] || fin_im[ACC_W]) ? ST_SAT : ST_OK;
            end
         end
         NRM_DONE: begin
         end
         default: begin
         end
      endcase
   end

endmodule

FILE: rtl/dpa_outq.sv
module dpa_outq import dpa_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  rsp_type            push_data,
   input  logic               pop,
   output rsp_type            head,
   output logic               not_empty,
   output logic [OUTQ_CW-1:0] count
);

   rsp_type              buf_ff [OUTQ_DEPTH];
   logic [OUTQ_AW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [OUTQ_CW-1:0]   cnt_ff;

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + OUTQ_AW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + OUTQ_AW'(1);
         end
         cnt_ff <= cnt_ff + OUTQ_CW'(push) - OUTQ_CW'(pop);
      end
   end

   // entries
   always_ff @(posedge clock) begin
      if (push) begin
         buf_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head      = buf_ff[rd_ptr_ff];
   assign not_empty = (cnt_ff != '0);
   assign count     = cnt_ff;

endmodule

FILE: rtl/dft_phasor_accumulator.sv
// Channel   Direction  Handshake          Payload
// req_      in         valid / stall      mode, freq, vertex, component, split_a, split_b
// rsp_      out        valid / stall      acc_re, acc_im, status
// csr_      in         valid / ready      index, wdata (always ready)
//
// Accumulate and read transactions: one per cycle while req_stall is low;
// the memory read-modify-write runs over 4 stages with forwarding of the last 3 writes.
// In-range normalise transactions run through the bit-serial divider (49 steps);
// no further transaction is taken until the quotient is written back.
// After reset a clearing pass writes zero to all MAX_FREQS*6*MAX_VERTICES entries,
// one per cycle, with req_stall high; configuration writes are taken meanwhile.
// req_stall also rises when the 8-entry result queue has no room left for a new result.
module dft_phasor_accumulator import dpa_pkg::*; #(
   parameter int MAX_VERTICES = 1024,
   parameter int MAX_FREQS    = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [1:0]                req_mode,
   input  logic [2:0]                req_freq_index,
   input  logic [9:0]                req_vertex_index,
   input  logic [2:0]                req_component,
   input  logic signed [SPLIT_W-1:0] req_split_a,
   input  logic signed [SPLIT_W-1:0] req_split_b,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [ACC_W-1:0]   rsp_acc_re,
   output logic signed [ACC_W-1:0]   rsp_acc_im,
   output logic [1:0]                rsp_status,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [2:0]                csr_index,
   input  logic [CFG_W-1:0]          csr_wdata
);

   localparam int DEPTH  = MAX_FREQS * NCOMP * MAX_VERTICES;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int DATA_W = 2 * ACC_W;
   localparam int NWB    = 3;

   // configuration
   logic signed [CFG_W-1:0] cfg_ff [NCFG];

   // clearing pass
   logic              clearing_ff;
   logic [ADDR_W-1:0] clr_addr_ff;

   // stage 0
   logic              req_accept;
   logic              in_range;
   logic [ADDR_W-1:0] req_addr;

   // stage 1
   logic              s1_vld_ff, s1_hit_ff, s1_is_h_ff;
   logic [1:0]        s1_mode_ff;
   logic [ADDR_W-1:0] s1_addr_ff;
   logic signed [32:0] s1_sum_ff;
   logic signed [CFG_W-1:0] ph_re, ph_im;

   // stage 2
   logic              s2_vld_ff, s2_hit_ff, s2_is_h_ff;
   logic [1:0]        s2_mode_ff;
   logic [ADDR_W-1:0] s2_addr_ff;
   logic signed [64:0] s2_prod_re_ff, s2_prod_im_ff;
   logic [DATA_W-1:0] s2_base_ff;

   // stage 3
   logic              s3_vld_ff, s3_hit_ff, s3_is_h_ff;
   logic [1:0]        s3_mode_ff;
   logic [ADDR_W-1:0] s3_addr_ff;
   logic signed [ACC_W-1:0] s3_inc_re_ff, s3_inc_im_ff;
   logic [DATA_W-1:0] s3_base_ff;
   logic [DATA_W-1:0] s3_entry;
   logic [ACC_W:0]    sum_re, sum_im;
   logic              s3_we, s3_push, nrm_start;
   rsp_type           s3_rsp;

   // recent writes not yet seen by the memory read
   logic              wb_we_ff   [NWB];
   logic [ADDR_W-1:0] wb_addr_ff [NWB];
   logic [DATA_W-1:0] wb_data_ff [NWB];

   // memory ports
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [DATA_W-1:0] mem_wdata, mem_rdata;

   // normalise unit
   logic              norm_busy_ff;
   logic [ADDR_W-1:0] norm_addr_ff;
   norm_req_type      nrm_req;
   logic              nrm_done;
   rsp_type           nrm_rsp;

   // output queue
   logic              outq_push, outq_pop;
   rsp_type           outq_data, outq_head;
   logic [OUTQ_CW-1:0] outq_count;
   logic [OUTQ_CW:0]  pending;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NCFG; i++) begin
            if ((i == int'(CSR_NORM_E_RE)) || (i == int'(CSR_NORM_H_RE))) begin
               cfg_ff[i] <= NORM_ONE;
            end else begin
               cfg_ff[i] <= '0;
            end
         end
      end else if (csr_valid && csr_ready) begin
         cfg_ff[csr_index] <= csr_wdata;
      end
   end

   // clearing pass after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clearing_ff) begin
         clr_addr_ff <= clr_addr_ff + ADDR_W'(1);
         if (clr_addr_ff == ADDR_W'(DEPTH - 1)) begin
            clearing_ff <= 1'b0;
         end
      end
   end

   // admission: room in the result queue for everything in flight
   always_comb begin
      pending   = (OUTQ_CW + 1)'(outq_count) + (OUTQ_CW + 1)'(s1_vld_ff)
                + (OUTQ_CW + 1)'(s2_vld_ff) + (OUTQ_CW + 1)'(s3_vld_ff)
                + (OUTQ_CW + 1)'(norm_busy_ff);
      req_stall = clearing_ff || norm_busy_ff || (pending >= (OUTQ_CW + 1)'(OUTQ_DEPTH));
   end

   assign req_accept = req_valid && !req_stall;

   // stage 0: range check and entry address
   always_comb begin
      in_range = (int'(req_freq_index) < MAX_FREQS)
              && (int'(req_vertex_index) < MAX_VERTICES)
              && (int'(req_component) < NCOMP);
      req_addr = ADDR_W'((int'(req_freq_index) * NCOMP + int'(req_component)) * MAX_VERTICES
                         + int'(req_vertex_index));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= req_accept;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
      end
   end

   // stage 1 capture
   always_ff @(posedge clock) begin
      s1_hit_ff  <= in_range;
      s1_is_h_ff <= (int'(req_component) >= COMP_H_BASE);
      s1_mode_ff <= req_mode;
      s1_addr_ff <= req_addr;
      s1_sum_ff  <= 33'(req_split_a) + 33'(req_split_b);
   end

   // stage 1: phase factor products
   always_comb begin
      ph_re = s1_is_h_ff ? cfg_ff[CSR_PHASE_H_RE] : cfg_ff[CSR_PHASE_E_RE];
      ph_im = s1_is_h_ff ? cfg_ff[CSR_PHASE_H_IM] : cfg_ff[CSR_PHASE_E_IM];
   end

   always_ff @(posedge clock) begin
      s2_hit_ff     <= s1_hit_ff;
      s2_is_h_ff    <= s1_is_h_ff;
      s2_mode_ff    <= s1_mode_ff;
      s2_addr_ff    <= s1_addr_ff;
      s2_prod_re_ff <= s1_sum_ff * ph_re;
      s2_prod_im_ff <= s1_sum_ff * ph_im;
      s2_base_ff    <= mem_rdata;
   end

   // stage 2: round products to Q8.40
   always_ff @(posedge clock) begin
      s3_hit_ff    <= s2_hit_ff;
      s3_is_h_ff   <= s2_is_h_ff;
      s3_mode_ff   <= s2_mode_ff;
      s3_addr_ff   <= s2_addr_ff;
      s3_inc_re_ff <= round_phase(s2_prod_re_ff);
      s3_inc_im_ff <= round_phase(s2_prod_im_ff);
      s3_base_ff   <= s2_base_ff;
   end

   // stage 3: forward the newest write to the same entry
   always_comb begin
      priority if (wb_we_ff[0] && (wb_addr_ff[0] == s3_addr_ff)) begin
         s3_entry = wb_data_ff[0];
      end else if (wb_we_ff[1] && (wb_addr_ff[1] == s3_addr_ff)) begin
         s3_entry = wb_data_ff[1];
      end else if (wb_we_ff[2] && (wb_addr_ff[2] == s3_addr_ff)) begin
         s3_entry = wb_data_ff[2];
      end else begin
         s3_entry = s3_base_ff;
      end
   end

   // stage 3: accumulate, read, hand over to the divider, or answer zero when out of range
   always_comb begin
      sum_re    = sat49(49'($signed(s3_entry[DATA_W-1:ACC_W])) + 49'(s3_inc_re_ff));
      sum_im    = sat49(49'($signed(s3_entry[ACC_W-1:0])) + 49'(s3_inc_im_ff));
      s3_we     = 1'b0;
      s3_push   = 1'b0;
      nrm_start = 1'b0;
      s3_rsp.acc_re = s3_entry[DATA_W-1:ACC_W];
      s3_rsp.acc_im = s3_entry[ACC_W-1:0];
      s3_rsp.status = ST_OK;
      if (s3_vld_ff) begin
         if (!s3_hit_ff) begin
            s3_push       = 1'b1;
            s3_rsp.acc_re = '0;
            s3_rsp.acc_im = '0;
         end else begin
            unique case (s3_mode_ff)
               MODE_ACC: begin
                  s3_we         = 1'b1;
                  s3_push       = 1'b1;
                  s3_rsp.acc_re = sum_re[ACC_W-1:0];
                  s3_rsp.acc_im = sum_im[ACC_W-1:0];
                  s3_rsp.status = (sum_re[ACC_W] || sum_im[ACC_W]) ? ST_SAT : ST_OK;
               end
               MODE_NORM: begin
                  nrm_start = 1'b1;
               end
               default: begin
                  s3_push = 1'b1;
               end
            endcase
         end
      end
   end

   // divider request
   always_comb begin
      nrm_req.x = s3_entry[DATA_W-1:ACC_W];
      nrm_req.y = s3_entry[ACC_W-1:0];
      nrm_req.c = s3_is_h_ff ? cfg_ff[CSR_NORM_H_RE] : cfg_ff[CSR_NORM_E_RE];
      nrm_req.d = s3_is_h_ff ? cfg_ff[CSR_NORM_H_IM] : cfg_ff[CSR_NORM_E_IM];
   end

   // only an in-range normalise reaches the divider
   always_ff @(posedge clock) begin
      if (reset) begin
         norm_busy_ff <= 1'b0;
      end else if (req_accept && (req_mode == MODE_NORM) && in_range) begin
         norm_busy_ff <= 1'b1;
      end else if (nrm_done) begin
         norm_busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (nrm_start) begin
         norm_addr_ff <= s3_addr_ff;
      end
   end

   dpa_norm u_norm (
      .clock (clock),
      .reset (reset),
      .start (nrm_start),
      .req   (nrm_req),
      .done  (nrm_done),
      .rsp   (nrm_rsp)
   );

   // memory write port
   always_comb begin
      priority if (clearing_ff) begin
         mem_we    = 1'b1;
         mem_waddr = clr_addr_ff;
         mem_wdata = '0;
      end else if (nrm_done) begin
         mem_we    = 1'b1;
         mem_waddr = norm_addr_ff;
         mem_wdata = {nrm_rsp.acc_re, nrm_rsp.acc_im};
      end else begin
         mem_we    = s3_we;
         mem_waddr = s3_addr_ff;
         mem_wdata = {s3_rsp.acc_re, s3_rsp.acc_im};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NWB; i++) begin
            wb_we_ff[i] <= 1'b0;
         end
      end else begin
         wb_we_ff[0] <= mem_we;
         for (int i = 1; i < NWB; i++) begin
            wb_we_ff[i] <= wb_we_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      wb_addr_ff[0] <= mem_waddr;
      wb_data_ff[0] <= mem_wdata;
      for (int i = 1; i < NWB; i++) begin
         wb_addr_ff[i] <= wb_addr_ff[i-1];
         wb_data_ff[i] <= wb_data_ff[i-1];
      end
   end

   dpa_store #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W),
      .DATA_W (DATA_W)
   ) u_store (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (req_addr),
      .rdata (mem_rdata)
   );

   // result queue
   assign outq_push = s3_push || nrm_done;
   assign outq_data = nrm_done ? nrm_rsp : s3_rsp;
   assign outq_pop  = rsp_valid && !rsp_stall;

   dpa_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (outq_push),
      .push_data (outq_data),
      .pop       (outq_pop),
      .head      (outq_head),
      .not_empty (rsp_valid),
      .count     (outq_count)
   );

   assign rsp_acc_re = $signed(outq_head.acc_re);
   assign rsp_acc_im = $signed(outq_head.acc_im);
   assign rsp_status = outq_head.status;

`ifndef SYNTHESIS
   // divider result never collides with a pipeline write
   a_write_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(nrm_done && (s3_we || s3_push)))
      else $error("divider and pipeline write in the same cycle");

   // admission control keeps the result queue from overflowing
   a_outq_room: assert property (@(posedge clock) disable iff (reset)
      (outq_push && !outq_pop) |-> (outq_count < OUTQ_CW'(OUTQ_DEPTH)))
      else $error("result queue overflow");

   // nothing reaches the pipeline while the store is being cleared
   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      clearing_ff |-> !(s1_vld_ff || s2_vld_ff || s3_vld_ff || outq_push))
      else $error("transaction in flight during clearing pass");

   // after a divider start the normalise stays pending and no new transaction enters stage 1 behind it
   a_norm_single: assert property (@(posedge clock) disable iff (reset)
      nrm_start |=> (norm_busy_ff && !s1_vld_ff))
      else $error("transaction accepted behind a pending normalise");
`endif

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import dpa_pkg::*;

   localparam int MAX_VERTICES = 1024;
   localparam int MAX_FREQS    = 8;
   localparam logic [1:0] MODE_READ  = 2'd2;
   localparam logic [1:0] MODE_SPARE = 2'd3;
   localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

   typedef struct {
      logic signed [ACC_W-1:0] acc_re;
      logic signed [ACC_W-1:0] acc_im;
      status_type              status;
   } phasor_result_t;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [1:0] req_mode = '0;
   logic [2:0] req_freq_index = '0;
   logic [9:0] req_vertex_index = '0;
   logic [2:0] req_component = '0;
   logic signed [SPLIT_W-1:0] req_split_a = '0;
   logic signed [SPLIT_W-1:0] req_split_b = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic signed [ACC_W-1:0] rsp_acc_re;
   logic signed [ACC_W-1:0] rsp_acc_im;
   logic [1:0] rsp_status;
   logic csr_valid = 0;
   logic csr_ready;
   logic [2:0] csr_index = '0;
   logic [CFG_W-1:0] csr_wdata = '0;

   dft_phasor_accumulator #(
      .MAX_VERTICES(MAX_VERTICES),
      .MAX_FREQS(MAX_FREQS)
   ) dut (.*);

   // 20 ns clock
   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   // predictor state
   logic signed [CFG_W-1:0] csr_shadow [NCFG];
   logic signed [ACC_W-1:0] store_re [int];
   logic signed [ACC_W-1:0] store_im [int];
   phasor_result_t expected_results [$];

   int mismatch_count = 0;
   bit no_idle = 0;
   int rx_gap = 0;
   int rx_hold = 0;

   task automatic report_mismatch(input string what);
      $display("ERROR at %0t: %s", $realtime, what);
      mismatch_count++;
   endtask

   // Q.58 product rounded to Q.40, halves away from zero
   function automatic logic signed [49:0] phase_term(input logic signed [32:0] s,
                                                     input logic signed [31:0] p);
      logic signed [64:0] prod;
      logic [64:0] mag;
      logic [64:0] r;
      prod = s * p;
      mag  = prod[64] ? -prod : prod;
      r    = (mag + 65'd131072) >> 18;
      return prod[64] ? -$signed({1'b0, r[48:0]}) : $signed({1'b0, r[48:0]});
   endfunction

   function automatic logic signed [ACC_W-1:0] clamp48(input logic signed [49:0] v,
                                                      inout bit flag);
      if (v > 50'sh7FFF_FFFF_FFFF) begin
         flag = 1;
         return 48'sh7FFF_FFFF_FFFF;
      end
      if (v < -50'sh8000_0000_0000) begin
         flag = 1;
         return 48'sh8000_0000_0000;
      end
      return v[47:0];
   endfunction

   // signed dot * 2^28 / den, rounded half away from zero, saturated
   function automatic logic signed [ACC_W-1:0] norm_quotient(input logic signed [81:0] dot,
                                                            input logic [63:0] den,
                                                            inout bit flag);
      logic [127:0] num, q, r, limit;
      bit neg;
      neg   = dot[81];
      num   = neg ? 128'(-dot) : 128'(dot);
      num   = num << 28;
      q     = num / den;
      r     = num % den;
      if (r >= 128'(den) - r) q++;
      limit = neg ? 128'h8000_0000_0000 : 128'h7FFF_FFFF_FFFF;
      if (q > limit) begin
         flag = 1;
         return neg ? 48'sh8000_0000_0000 : 48'sh7FFF_FFFF_FFFF;
      end
      return neg ? -q[47:0] : q[47:0];
   endfunction

   // expected entry after one transaction; updates the store copy for in-range entries
   function automatic phasor_result_t predict_entry(input logic [1:0] mode,
         input logic [2:0] f, input logic [9:0] v, input logic [2:0] c,
         input logic signed [31:0] a, input logic signed [31:0] b);
      phasor_result_t res;
      int addr;
      bit is_h, sat;
      logic signed [32:0] s;
      logic signed [31:0] nc, nd;
      logic [63:0] den;
      logic signed [81:0] dot_re, dot_im;
      logic signed [ACC_W-1:0] x, y;
      res = '{0, 0, ST_OK};
      if (f >= MAX_FREQS || v >= MAX_VERTICES || c >= NCOMP) return res;
      addr = (f * NCOMP + c) * MAX_VERTICES + v;
      is_h = c >= COMP_H_BASE;
      sat  = 0;
      x = store_re.exists(addr) ? store_re[addr] : '0;
      y = store_im.exists(addr) ? store_im[addr] : '0;
      if (mode == MODE_ACC) begin
         s = a + b;
         s = 33'(a) + 33'(b);
         res.acc_re = clamp48(50'(x) + phase_term(s, csr_shadow[is_h ? CSR_PHASE_H_RE
                                                              : CSR_PHASE_E_RE]), sat);
         res.acc_im = clamp48(50'(y) + phase_term(s, csr_shadow[is_h ? CSR_PHASE_H_IM
                                                              : CSR_PHASE_E_IM]), sat);
         res.status = sat ? ST_SAT : ST_OK;
      end else if (mode == MODE_NORM) begin
         nc  = csr_shadow[is_h ? CSR_NORM_H_RE : CSR_NORM_E_RE];
         nd  = csr_shadow[is_h ? CSR_NORM_H_IM : CSR_NORM_E_IM];
         den = 64'(nc * nc) + 64'(nd * nd);
         den = 64'($signed(64'(nc)) * $signed(64'(nc))) + 64'($signed(64'(nd)) * $signed(64'(nd)));
         if (den == 0) begin
            res = '{x, y, ST_DIV_ZERO};
         end else begin
            dot_re = 82'(x) * 82'(nc) + 82'(y) * 82'(nd);
            dot_im = 82'(y) * 82'(nc) - 82'(x) * 82'(nd);
            res.acc_re = norm_quotient(dot_re, den, sat);
            res.acc_im = norm_quotient(dot_im, den, sat);
            res.status = sat ? ST_SAT : ST_OK;
         end
      end else begin
         res = '{x, y, ST_OK};
      end
      store_re[addr] = res.acc_re;
      store_im[addr] = res.acc_im;
      return res;
   endfunction

   function automatic int draw_gap();
      return no_idle ? 0 : $urandom_range(0, 9);
   endfunction

   // offer one transaction, predict it once accepted
   task automatic send_item(input logic [1:0] mode, input logic [2:0] f,
         input logic [9:0] v, input logic [2:0] c,
         input logic signed [31:0] a, input logic signed [31:0] b);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1;
      req_mode         <= mode;
      req_freq_index   <= f;
      req_vertex_index <= v;
      req_component    <= c;
      req_split_a      <= a;
      req_split_b      <= b;
      do @(posedge clock); while (req_stall);
      expected_results.push_back(predict_entry(mode, f, v, c, a, b));
   endtask

   task automatic wait_drained();
      req_valid <= 0;
      while (expected_results.size() > 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // write all eight registers, one transaction each
   task automatic write_config(input logic [31:0] vals [NCFG]);
      wait_drained();
      for (int i = 0; i < NCFG; i++) begin
         csr_valid <= 1;
         csr_index <= 3'(i);
         csr_wdata <= vals[i];
         do @(posedge clock); while (!csr_ready);
         csr_shadow[i] = vals[i];
      end
      csr_valid <= 0;
   endtask

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 4))
         0: return S32_MAX;
         1: return S32_MIN;
         2: return $urandom_range(0, 65535) - 32768;
         default: return $urandom;
      endcase
   endfunction

   // entries are drawn mostly from a small pool so that operations stack up
   task automatic send_random();
      logic [1:0] mode;
      logic [2:0] f, c;
      logic [9:0] v;
      int r;
      r = $urandom_range(0, 99);
      mode = r < 60 ? MODE_ACC : r < 68 ? MODE_NORM : r < 94 ? MODE_READ : MODE_SPARE;
      if ($urandom_range(0, 9) < 8) begin
         f = $urandom_range(0, 1) ? 3'd7 : 3'd0;
         v = $urandom_range(0, 1) ? 10'd1023 : 10'($urandom_range(0, 2));
         c = 3'($urandom_range(0, 5));
      end else begin
         f = 3'($urandom);
         v = 10'($urandom);
         c = 3'($urandom);
      end
      send_item(mode, f, v, c, rand_word(), rand_word());
   endtask

   function automatic logic [31:0] rand_norm();
      case ($urandom_range(0, 3))
         0: return 0;
         1: return NORM_ONE + $urandom_range(0, 4095) - 2048;
         2: return $urandom_range(0, 255) - 128;
         default: return $urandom;
      endcase
   endfunction

   // result checker and receiver idling
   always @(posedge clock) begin
      phasor_result_t exp_res;
      if (rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            report_mismatch("result with none expected");
         end else begin
            exp_res = expected_results.pop_front();
            if (rsp_acc_re !== exp_res.acc_re)
               report_mismatch($sformatf("acc_re %h expected %h", rsp_acc_re, exp_res.acc_re));
            if (rsp_acc_im !== exp_res.acc_im)
               report_mismatch($sformatf("acc_im %h expected %h", rsp_acc_im, exp_res.acc_im));
            if (rsp_status !== exp_res.status)
               report_mismatch($sformatf("status %0d expected %0d", rsp_status, exp_res.status));
         end
         rx_gap = draw_gap();
      end
      if (rx_hold > 0) begin
         rx_hold--;
         rsp_stall <= 1;
      end else if (rx_gap > 0) begin
         rx_gap--;
         rsp_stall <= 1;
      end else begin
         rsp_stall <= 0;
      end
   end

   task automatic test_directed();
      logic [31:0] cfg [NCFG];
      cfg = '{S32_MAX, S32_MIN, S32_MIN, S32_MAX, NORM_ONE, 0, 32'sh0800_0000, 32'sh0800_0000};
      write_config(cfg);
      send_item(MODE_ACC, 3'd0, 10'd0, 3'd0, S32_MAX, S32_MAX);
      send_item(MODE_ACC, 3'd0, 10'd0, 3'd0, S32_MIN, S32_MIN);
      send_item(MODE_ACC, 3'd7, 10'd1023, 3'd5, S32_MAX, S32_MAX);
      // repeated large additions drive both parts into saturation
      repeat (10) send_item(MODE_ACC, 3'd7, 10'd1023, 3'd2, S32_MAX, S32_MAX);
      send_item(MODE_NORM, 3'd7, 10'd1023, 3'd2, 0, 0);
      send_item(MODE_NORM, 3'd7, 10'd1023, 3'd5, 0, 0);
      send_item(MODE_READ, 3'd7, 10'd1023, 3'd5, S32_MAX, S32_MIN);
      send_item(MODE_SPARE, 3'd0, 10'd0, 3'd0, S32_MIN, S32_MAX);
      // components past Hz touch nothing
      send_item(MODE_ACC, 3'd7, 10'd1023, 3'd6, S32_MAX, S32_MAX);
      send_item(MODE_NORM, 3'd5, 10'd512, 3'd7, 0, 0);
      // zero divisor on both sets
      cfg = '{NORM_ONE, 0, 0, NORM_ONE, 0, 0, 0, 0};
      write_config(cfg);
      send_item(MODE_NORM, 3'd7, 10'd1023, 3'd2, 0, 0);
      send_item(MODE_NORM, 3'd7, 10'd1023, 3'd5, 0, 0);
      // tiny divisor on the E set saturates the quotient
      cfg = '{S32_MAX, S32_MAX, S32_MAX, S32_MAX, 1, 0, S32_MIN, S32_MIN};
      write_config(cfg);
      send_item(MODE_NORM, 3'd7, 10'd1023, 3'd2, 0, 0);
      send_item(MODE_NORM, 3'd7, 10'd1023, 3'd5, 0, 0);
   endtask

   task automatic test_random(input int count);
      logic [31:0] cfg [NCFG];
      for (int ph = 0; ph < 5; ph++) begin
         for (int i = 0; i < 4; i++) cfg[i] = rand_word();
         for (int i = 4; i < NCFG; i++) cfg[i] = rand_norm();
         write_config(cfg);
         no_idle = ph == 2;
         repeat (count / 5) send_random();
      end
      no_idle = 0;
   endtask

   // receiver holds off while the sender keeps offering
   task automatic test_backpressure();
      no_idle = 1;
      rx_hold = 400;
      repeat (40) send_random();
      no_idle = 0;
   endtask

   // sender pauses until every result is in, then resumes
   task automatic test_drain_pause();
      repeat (30) send_random();
      wait_drained();
      repeat (30) send_random();
   endtask

   initial begin
      for (int i = 0; i < NCFG; i++) csr_shadow[i] = 0;
      csr_shadow[CSR_NORM_E_RE] = NORM_ONE;
      csr_shadow[CSR_NORM_H_RE] = NORM_ONE;
      repeat (12) @(posedge clock);
      reset <= 0;
      test_directed();
      test_backpressure();
      test_drain_pause();
      test_random(1250);
      wait_drained();
      repeat (100) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // watchdog
   initial begin
      #40_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule
